// ===== rtl/deadline_priority_order_queue_defines.svh =====
// Assertion macros for the deadline priority order queue RTL, used by dpoq_ctrl.
`ifndef DEADLINE_PRIORITY_ORDER_QUEUE_DEFINES_SVH
`define DEADLINE_PRIORITY_ORDER_QUEUE_DEFINES_SVH

// Property that must hold at every clock edge out of reset.
`define DPOQ_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("dpoq: invariant violated");

// Same-cycle implication checked at every clock edge out of reset.
`define DPOQ_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dpoq: implication violated");

`endif

// ===== rtl/dpoq_pkg.sv =====
// Shared constants and types for the deadline priority order queue.
package dpoq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ID_BITS     = 16;

    localparam int SLOT_W        = $clog2(QUEUE_DEPTH);
    localparam int CNT_W         = $clog2(QUEUE_DEPTH + 1);
    localparam int ORDER_ID_W    = 16;
    localparam int KIND_W        = 2;
    localparam int DUE_W         = 32;
    localparam int POS_W         = 4;
    localparam int ENTRY_COUNT_W = 5;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    localparam logic [KIND_W-1:0] KIND_TRANSFORM = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD      = 2'd1;
    localparam logic [KIND_W-1:0] KIND_UNLOAD    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_INVALID   = 2'd3;

    typedef struct packed {
        logic               valid;
        logic [ID_BITS-1:0] id;
        logic [KIND_W-1:0]  kind;
        logic [DUE_W-1:0]   due;
    } entry_t;

    typedef struct packed {
        logic               mode;
        logic [ID_BITS-1:0] id;
        logic [KIND_W-1:0]  kind;
        logic [DUE_W-1:0]   due;
    } op_t;

    // Commands broadcast to every cell
    typedef struct packed {
        logic eval;   // latch per-cell compare result
        logic ins;    // commit insert: shift toward tail from the slot
        logic rem;    // commit remove: shift toward head from the match
    } cmd_t;

    // Status gathered from the chain
    typedef struct packed {
        logic [QUEUE_DEPTH-1:0] first;
        logic [QUEUE_DEPTH-1:0] valid;
        logic                   found;
    } stat_t;

endpackage

// ===== rtl/dpoq_cell.sv =====
// One queue slot: holds an entry, compares it, and shifts with its neighbors.
module dpoq_cell
    import dpoq_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  op_t    op,
    input  cmd_t   cmd,
    input  entry_t left,
    input  entry_t right,
    input  logic   prior_hit,
    output entry_t ent,
    output logic   hit,
    output logic   first
);

    logic               valid_reg;
    logic               valid_next;
    logic [ID_BITS-1:0] id_reg;
    logic [ID_BITS-1:0] id_next;
    logic [KIND_W-1:0]  kind_reg;
    logic [KIND_W-1:0]  kind_next;
    logic [DUE_W-1:0]   due_reg;
    logic [DUE_W-1:0]   due_next;
    logic               flag_reg;
    logic               flag_next;
    entry_t             fresh;
    entry_t             take;
    logic               load;

    assign ent.valid = valid_reg;
    assign ent.id    = id_reg;
    assign ent.kind  = kind_reg;
    assign ent.due   = due_reg;

    assign hit   = prior_hit | flag_reg;
    assign first = flag_reg & ~prior_hit;

    assign fresh.valid = 1'b1;
    assign fresh.id    = op.id;
    assign fresh.kind  = op.kind;
    assign fresh.due   = (op.kind == KIND_TRANSFORM) ? op.due : '0;

    // insert stops at the first empty slot or the first later transform entry (any transform entry for load/unload)
    always_comb
    begin
        flag_next = flag_reg;
        if (cmd.eval)
        begin
            if (op.mode == MODE_INSERT)
            begin
                flag_next = ~valid_reg
                    | ((kind_reg == KIND_TRANSFORM)
                       & ((op.kind != KIND_TRANSFORM) | (op.due < due_reg)));
            end
            else
            begin
                flag_next = valid_reg & (id_reg == op.id);
            end
        end
    end

    always_comb
    begin
        load = 1'b0;
        take = right;
        if (cmd.ins)
        begin
            if (prior_hit)
            begin
                load = 1'b1;
                take = left;
            end
            else if (flag_reg)
            begin
                load = 1'b1;
                take = fresh;
            end
        end
        else if (cmd.rem)
        begin
            if (hit)
            begin
                load = 1'b1;
                take = right;
            end
        end
        valid_next = load ? take.valid : valid_reg;
        id_next    = load ? take.id    : id_reg;
        kind_next  = load ? take.kind  : kind_reg;
        due_next   = load ? take.due   : due_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            flag_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            flag_reg  <= flag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg   <= id_next;
        kind_reg <= kind_next;
        due_reg  <= due_next;
    end

endmodule

// ===== rtl/dpoq_ctrl.sv =====
// Sequencer, occupancy count and result register for the order queue.
`include "deadline_priority_order_queue_defines.svh"

module dpoq_ctrl
    import dpoq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     mode,
    input  logic [ORDER_ID_W-1:0]    order_id,
    input  logic [KIND_W-1:0]        order_kind,
    input  logic [DUE_W-1:0]         deadline,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     ok,
    output logic [POS_W-1:0]         position,
    output logic                     queue_full,
    output logic [ENTRY_COUNT_W-1:0] entry_count,
    output op_t                      op,
    output cmd_t                     cmd,
    input  stat_t                    stat
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EVAL  = 2'd1;
    localparam logic [1:0] S_APPLY = 2'd2;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    op_t              op_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             ok_reg;
    logic [SLOT_W-1:0] pos_reg;
    logic             full_reg;
    logic             is_full;
    logic             ins_go;
    logic             rem_go;
    logic             apply_fire;
    logic             in_acc;
    logic [SLOT_W-1:0] slot_enc;

    assign is_full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign ins_go     = (op_reg.mode == MODE_INSERT) & ~is_full
                        & (op_reg.kind != KIND_INVALID);
    assign rem_go     = (op_reg.mode == MODE_REMOVE) & stat.found;
    assign apply_fire = (state_reg == S_APPLY) & (~out_valid_reg | ~out_stall);
    assign in_stall   = ~((state_reg == S_IDLE) | apply_fire);
    assign in_acc     = in_valid & ~in_stall;

    assign op       = op_reg;
    assign cmd.eval = (state_reg == S_EVAL);
    assign cmd.ins  = apply_fire & ins_go;
    assign cmd.rem  = apply_fire & rem_go;

    always_comb
    begin
        slot_enc = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (stat.first[i])
            begin
                slot_enc = slot_enc | SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                if (apply_fire)
                begin
                    state_next = in_acc ? S_EVAL : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.ins)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.rem)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        out_valid_next = out_valid_reg;
        if (apply_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg & ~out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            op_reg.mode <= mode;
            op_reg.id   <= ID_BITS'(order_id);
            op_reg.kind <= order_kind;
            op_reg.due  <= deadline;
        end
        if (apply_fire)
        begin
            ok_reg   <= ins_go | rem_go;
            pos_reg  <= (ins_go | rem_go) ? slot_enc : '0;
            full_reg <= (op_reg.mode == MODE_INSERT) & is_full;
        end
    end

    assign out_valid   = out_valid_reg;
    assign ok          = ok_reg;
    assign position    = POS_W'(pos_reg);
    assign queue_full  = full_reg;
    assign entry_count = ENTRY_COUNT_W'(count_reg);

    `DPOQ_ASSERT_ALWAYS(a_count_range, count_reg <= CNT_W'(QUEUE_DEPTH))
    `DPOQ_ASSERT_ALWAYS(a_valid_matches_count, $countones(stat.valid) == int'(count_reg))
    `DPOQ_ASSERT_ALWAYS(a_single_first, $onehot0(stat.first))
    `DPOQ_ASSERT_IMPLY(a_insert_has_slot, (state_reg == S_APPLY) && ins_go, stat.found)
    `DPOQ_ASSERT_IMPLY(a_full_not_ok, out_valid_reg && full_reg, !ok_reg)

endmodule

// ===== rtl/deadline_priority_order_queue.sv =====
// Top level of the deadline priority order queue: control plus a chain of slot cells.
//
//   channel | handshake            | payload
//   --------+----------------------+--------------------------------------------------
//   in      | in_valid / in_stall  | mode, order_id, order_kind, deadline
//   out     | out_valid / out_stall| ok, position, queue_full, entry_count,
//           |                      | head_id, head_kind
//
// A transaction runs in two states: EVAL latches every cell's compare (deadline or id),
// then APPLY resolves the first hit along the chain and shifts the cells. A following
// transaction can be taken as the last one commits; back to back ones alternate the two.
// Reset clears every cell's valid bit, the count and the sequencer; entry payload is
// not reset. A stalled result holds the commit step, so the queue never runs ahead
// of the output register by more than one result.
module deadline_priority_order_queue
    import dpoq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     mode,
    input  logic [ORDER_ID_W-1:0]    order_id,
    input  logic [KIND_W-1:0]        order_kind,
    input  logic [DUE_W-1:0]         deadline,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     ok,
    output logic [POS_W-1:0]         position,
    output logic                     queue_full,
    output logic [ENTRY_COUNT_W-1:0] entry_count,
    output logic [ORDER_ID_W-1:0]    head_id,
    output logic [KIND_W-1:0]        head_kind
);

    op_t                  op;
    cmd_t                 cmd;
    stat_t                stat;
    entry_t               ents [QUEUE_DEPTH];
    logic [QUEUE_DEPTH:0] hit_chain;

    dpoq_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .order_id    (order_id),
        .order_kind  (order_kind),
        .deadline    (deadline),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .ok          (ok),
        .position    (position),
        .queue_full  (queue_full),
        .entry_count (entry_count),
        .op          (op),
        .cmd         (cmd),
        .stat        (stat)
    );

    // Hit ripples from the head: a cell behind the first hit shifts.
    assign hit_chain[0] = 1'b0;

    for (genvar g = 0; g < QUEUE_DEPTH; g++)
    begin : g_cell
        entry_t left_ent;
        entry_t right_ent;

        if (g == 0)
        begin : g_head
            assign left_ent = '0;
        end
        else
        begin : g_mid_l
            assign left_ent = ents[g-1];
        end

        // The tail cell pulls in an empty slot on remove.
        if (g == QUEUE_DEPTH - 1)
        begin : g_tail
            assign right_ent = '0;
        end
        else
        begin : g_mid_r
            assign right_ent = ents[g+1];
        end

        dpoq_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .op        (op),
            .cmd       (cmd),
            .left      (left_ent),
            .right     (right_ent),
            .prior_hit (hit_chain[g]),
            .ent       (ents[g]),
            .hit       (hit_chain[g+1]),
            .first     (stat.first[g])
        );

        assign stat.valid[g] = ents[g].valid;
    end

    assign stat.found = hit_chain[QUEUE_DEPTH];

    // Head comes straight from cell 0; it only moves on a commit, which waits
    // for the result register to drain.
    assign head_id   = ents[0].valid ? ORDER_ID_W'(ents[0].id) : '0;
    assign head_kind = ents[0].valid ? ents[0].kind : '0;

endmodule

// ===== tb/sv/deadline_priority_order_queue_tb.sv =====
// Self-checking testbench for the deadline priority order queue.
`timescale 1ns / 100ps

module deadline_priority_order_queue_tb;
    import dpoq_pkg::*;

    // Status the queue reports after each transaction
    typedef struct packed {
        logic                     ok;
        logic [POS_W-1:0]         position;
        logic                     queue_full;
        logic [ENTRY_COUNT_W-1:0] entry_count;
        logic [ORDER_ID_W-1:0]    head_id;
        logic [KIND_W-1:0]        head_kind;
    } queue_status_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic                     mode = MODE_INSERT;
    logic [ORDER_ID_W-1:0]    order_id = '0;
    logic [KIND_W-1:0]        order_kind = KIND_TRANSFORM;
    logic [DUE_W-1:0]         deadline = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic                     ok;
    logic [POS_W-1:0]         position;
    logic                     queue_full;
    logic [ENTRY_COUNT_W-1:0] entry_count;
    logic [ORDER_ID_W-1:0]    head_id;
    logic [KIND_W-1:0]        head_kind;

    deadline_priority_order_queue i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .order_id    (order_id),
        .order_kind  (order_kind),
        .deadline    (deadline),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .ok          (ok),
        .position    (position),
        .queue_full  (queue_full),
        .entry_count (entry_count),
        .head_id     (head_id),
        .head_kind   (head_kind)
    );

    // Shadow copy of the order book, index 0 is the head
    logic [ORDER_ID_W-1:0] book_id   [QUEUE_DEPTH];
    logic [KIND_W-1:0]     book_kind [QUEUE_DEPTH];
    logic [DUE_W-1:0]      book_due  [QUEUE_DEPTH];
    int                    book_count = 0;

    queue_status_t expected_status[$];

    // Traffic shaping knobs shared by the test tasks and the receiver
    bit no_idle = 1'b0;        // both sides run without gaps
    bit sender_eager = 1'b0;   // sender offers every cycle
    int stall_hold_req = 0;    // receiver long hold, in cycles

    // Run statistics
    int fault_count = 0;
    int items_sent = 0;
    int results_checked = 0;
    int inserts_placed = 0;
    int full_drops = 0;
    int bad_kinds = 0;
    int removes_hit = 0;
    int removes_missed = 0;
    int peak_count = 0;

    initial begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Order book predictor. Urgent entries (load/unload) land just ahead
    // of the first transformation entry; a transformation lands ahead of
    // the first transformation with a strictly later deadline, so ties
    // keep arrival order. Remove drops only the first id match.
    // ------------------------------------------------------------------
    function automatic queue_status_t apply_order(logic op, logic [ORDER_ID_W-1:0] id,
                                                  logic [KIND_W-1:0] kind,
                                                  logic [DUE_W-1:0] due);
        queue_status_t r;
        int slot;
        int hit;
        int i;
        r = '0;
        if (op == MODE_INSERT) begin
            if (book_count >= QUEUE_DEPTH) begin
                r.queue_full = 1'b1;
            end else if (kind != KIND_INVALID) begin
                slot = book_count;
                // scan from the tail so the lowest qualifying index wins
                for (i = book_count - 1; i >= 0; i--) begin
                    if (book_kind[i] == KIND_TRANSFORM &&
                        (kind != KIND_TRANSFORM || due < book_due[i]))
                    begin
                        slot = i;
                    end
                end
                for (i = book_count; i > slot; i--) begin
                    book_id[i]   = book_id[i-1];
                    book_kind[i] = book_kind[i-1];
                    book_due[i]  = book_due[i-1];
                end
                book_id[slot]   = id;
                book_kind[slot] = kind;
                book_due[slot]  = (kind == KIND_TRANSFORM) ? due : '0;
                book_count++;
                r.ok = 1'b1;
                r.position = slot[POS_W-1:0];
            end
        end else begin
            hit = -1;
            for (i = book_count - 1; i >= 0; i--) begin
                if (book_id[i] == id) begin
                    hit = i;
                end
            end
            if (hit >= 0) begin
                for (i = hit; i + 1 < book_count; i++) begin
                    book_id[i]   = book_id[i+1];
                    book_kind[i] = book_kind[i+1];
                    book_due[i]  = book_due[i+1];
                end
                book_count--;
                r.ok = 1'b1;
                r.position = hit[POS_W-1:0];
            end
        end
        r.entry_count = book_count[ENTRY_COUNT_W-1:0];
        if (book_count > 0) begin
            r.head_id   = book_id[0];
            r.head_kind = book_kind[0];
        end
        return r;
    endfunction

    function automatic int draw_gap();
        if (no_idle || $urandom_range(0, 3) == 0) begin
            return 0;
        end
        return $urandom_range(0, 13);
    endfunction

    // ------------------------------------------------------------------
    // Send one transaction. Entered and left at a falling edge; valid
    // stays high on exit so a zero gap gives back-to-back offers.
    // ------------------------------------------------------------------
    task automatic send_order(logic op, logic [ORDER_ID_W-1:0] id,
                              logic [KIND_W-1:0] kind, logic [DUE_W-1:0] due);
        int gap;
        queue_status_t predicted;
        gap = sender_eager ? 0 : draw_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        mode       <= op;
        order_id   <= id;
        order_kind <= kind;
        deadline   <= due;
        in_valid   <= 1'b1;
        // in_stall read here is the value the block saw at this edge
        do @(posedge clk); while (in_stall);
        predicted = apply_order(op, id, kind, due);
        expected_status = {expected_status, predicted};
        items_sent++;
        if (op == MODE_INSERT) begin
            if (predicted.ok) inserts_placed++;
            else if (predicted.queue_full) full_drops++;
            else bad_kinds++;
        end else begin
            if (predicted.ok) removes_hit++;
            else removes_missed++;
        end
        if (book_count > peak_count) peak_count = book_count;
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall before each result, plus one long hold on
    // request so the block backs up into its input.
    // ------------------------------------------------------------------
    initial begin
        int n;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            if (stall_hold_req > 0) begin
                out_stall <= 1'b1;
                repeat (stall_hold_req) @(negedge clk);
                stall_hold_req = 0;
            end
            n = draw_gap();
            if (n > 0) begin
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!(out_valid && !out_stall));
            @(negedge clk);
        end
    end

    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            fault_count++;
            if (fault_count <= 50) begin
                $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
                         $time, field, want, got);
            end
        end
    endfunction

    // Result checker: every accepted result against the oldest expectation
    always @(posedge clk) begin
        queue_status_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_status.size() == 0) begin
                fault_count++;
                if (fault_count <= 50) begin
                    $display("%0t: stray result, expected none, got ok=%0b pos=%0d count=%0d",
                             $time, ok, position, entry_count);
                end
            end else begin
                want = expected_status.pop_front();
                results_checked++;
                check_field("ok",          32'(want.ok),          32'(ok));
                check_field("position",    32'(want.position),    32'(position));
                check_field("queue_full",  32'(want.queue_full),  32'(queue_full));
                check_field("entry_count", 32'(want.entry_count), 32'(entry_count));
                check_field("head_id",     32'(want.head_id),     32'(head_id));
                check_field("head_kind",   32'(want.head_kind),   32'(head_kind));
            end
        end
    end

    // ------------------------------------------------------------------
    // Random field pickers: small id pool for hits and duplicates, small
    // deadline pool for ties, plus full-range values to toggle every bit.
    // ------------------------------------------------------------------
    function automatic logic [ORDER_ID_W-1:0] pick_id();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return ORDER_ID_W'($urandom_range(0, 15));
        if (r == 6) return ($urandom_range(0, 1) != 0) ? '1 : '0;
        return ORDER_ID_W'($urandom_range(0, 65535));
    endfunction

    function automatic logic [KIND_W-1:0] pick_kind();
        int r;
        r = $urandom_range(0, 19);
        if (r < 11) return KIND_TRANSFORM;
        if (r < 15) return KIND_LOAD;
        if (r < 19) return KIND_UNLOAD;
        return KIND_INVALID;
    endfunction

    function automatic logic [DUE_W-1:0] pick_deadline();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return $urandom_range(0, 7);
        if (r == 4) begin
            case ($urandom_range(0, 3))
                0: return 32'h0000_0000;
                1: return 32'hFFFF_FFFF;
                2: return 32'h8000_0000;
                default: return 32'h7FFF_FFFF;
            endcase
        end
        return $urandom();
    endfunction

    // ------------------------------------------------------------------
    // Test tasks
    // ------------------------------------------------------------------

    // Empty queue: remove misses, bad kind rejected, head reads zero
    task automatic test_empty_queue();
        send_order(MODE_REMOVE, 16'h0000, KIND_TRANSFORM, 32'h0);
        send_order(MODE_INSERT, 16'h0007, KIND_INVALID, 32'hFFFF_FFFF);
    endtask

    // Placement rules, duplicate ids and removal from middle and tail
    task automatic test_ordering_rules();
        send_order(MODE_INSERT, 16'h0001, KIND_TRANSFORM, 32'd100);
        send_order(MODE_INSERT, 16'h0002, KIND_TRANSFORM, 32'd100);   // tie goes behind
        send_order(MODE_INSERT, 16'h0003, KIND_TRANSFORM, 32'd0);     // new head
        send_order(MODE_INSERT, 16'hFFFF, KIND_TRANSFORM, 32'hFFFF_FFFF);
        send_order(MODE_INSERT, 16'h0005, KIND_LOAD, 32'd1234);       // deadline dropped
        send_order(MODE_INSERT, 16'h0006, KIND_UNLOAD, 32'hFFFF_FFFF);
        send_order(MODE_INSERT, 16'h0001, KIND_LOAD, 32'd0);          // duplicate id
        send_order(MODE_INSERT, 16'h0008, KIND_INVALID, 32'd5);
        send_order(MODE_REMOVE, 16'h0001, KIND_TRANSFORM, 32'd0);     // first match only
        send_order(MODE_REMOVE, 16'hFFFF, KIND_UNLOAD, 32'd0);        // tail
        send_order(MODE_REMOVE, 16'h0000, KIND_TRANSFORM, 32'd0);     // absent
    endtask

    // Fill to capacity across the signed/unsigned deadline boundary,
    // then insert into the full queue, once with an invalid kind
    task automatic test_full_queue();
        int k;
        k = 0;
        while (book_count < QUEUE_DEPTH) begin
            send_order(MODE_INSERT, 16'h0100 + k[15:0], KIND_W'(k % 3),
                       (k % 2 != 0) ? 32'h8000_0000 + k : 32'h7FFF_FFFF - k);
            k++;
        end
        send_order(MODE_INSERT, 16'h0200, KIND_LOAD, 32'd0);
        send_order(MODE_INSERT, 16'h0201, KIND_INVALID, 32'd0);
    endtask

    // Random mix; insert_pct steers occupancy up or down
    task automatic test_random_traffic(int n_items, int insert_pct);
        int k;
        logic op;
        logic [ORDER_ID_W-1:0] id;
        logic [KIND_W-1:0] kind;
        logic [DUE_W-1:0] due;
        for (k = 0; k < n_items; k++) begin
            op   = ($urandom_range(1, 100) <= insert_pct) ? MODE_INSERT : MODE_REMOVE;
            kind = pick_kind();
            due  = pick_deadline();
            if (op == MODE_REMOVE && book_count > 0 && $urandom_range(0, 3) != 0) begin
                id = book_id[$urandom_range(0, book_count - 1)];
            end else begin
                id = pick_id();
            end
            send_order(op, id, kind, due);
        end
    endtask

    // No idling on either side: transactions go back to back, as fast as the block accepts them
    task automatic test_back_to_back();
        no_idle = 1'b1;
        test_random_traffic(200, 55);
        no_idle = 1'b0;
    endtask

    // Receiver holds off a long stretch while the sender keeps offering
    task automatic test_output_backpressure();
        stall_hold_req = 120;
        sender_eager = 1'b1;
        test_random_traffic(40, 70);
        sender_eager = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_queue();
        test_ordering_rules();
        test_full_queue();
        test_random_traffic(250, 30);   // drain from full
        test_random_traffic(250, 75);   // climb back up
        test_random_traffic(400, 50);
        test_back_to_back();
        test_output_backpressure();
        test_random_traffic(250, 50);

        in_valid <= 1'b0;
        while (expected_status.size() != 0) @(posedge clk);
        // quiet stretch to catch any stray result
        repeat (8) @(posedge clk);

        $display("summary: %0d transactions, %0d results checked, peak occupancy %0d",
                 items_sent, results_checked, peak_count);
        $display("summary: inserted %0d, full %0d, bad kind %0d, removed %0d, missed %0d",
                 inserts_placed, full_drops, bad_kinds, removes_hit, removes_missed);
        if (fault_count == 0) begin
            $display("deadline_priority_order_queue_tb: done, clean");
        end else begin
            $display("deadline_priority_order_queue_tb: done, errors");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("watchdog expired with %0d results outstanding", expected_status.size());
        $display("deadline_priority_order_queue_tb: done, errors");
        $finish;
    end

endmodule

// ===== deadline_priority_order_queue.f =====
+incdir+rtl
rtl/dpoq_pkg.sv
rtl/dpoq_cell.sv
rtl/dpoq_ctrl.sv
rtl/deadline_priority_order_queue.sv
tb/sv/deadline_priority_order_queue_tb.sv
